// File: src/brg_pkg.sv
// ----------------------------------------------------------------------------
// brg_pkg
// Shared types, fixed-point constants and elaboration-time table builders
// for the button gain recovery pipeline.
// ----------------------------------------------------------------------------
package brg_pkg;

   // per-item status carried down the pipeline
   typedef struct packed {
      logic zero;      // result forced to zero with no flag
      logic invalid;   // ratio not positive or denominator zero
      logic sat;       // result clipped to full scale
   } brg_flags_type;

   localparam int       DEN_W     = 34;   // Q24 denominator, signed
   localparam int       QUO_W     = 28;   // quotient bits, top bit is overflow
   localparam int       DIV_W     = 33;   // magnitude of the denominator
   localparam int       REM_W     = 49;   // dividend A << 24 fits here
   localparam int       MUD_W     = 28;

   localparam longint   K_CD_Q16  = 64'sd5052879864;
   localparam longint   K_F_Q16   = 64'sd116654;
   localparam longint   K_LOG10_2 = 64'sd5050445;
   localparam longint   K_LOG2_10 = 64'sd55732705;
   localparam longint   K_A       = 64'sd18975031;
   localparam longint   K_A_M1    = 64'sd2197815;
   localparam longint   K_B       = 64'sd68904026;
   localparam logic [63:0] DIV_NUM = 64'd18975031 << 24;
   localparam logic [QUO_W-1:0] T_SAT_LIM  = 28'd83886080;   // 5.0 in Q24
   localparam logic [QUO_W-1:0] T_TINY_LIM = 28'd100663296;  // 6.0 in Q24

   // log2(1 + k/2^tb) as a Q24 fraction, k in [0, 2^tb]
   function automatic logic [24:0] lg_point(logic [63:0] k, int tb);
      logic [63:0] m;
      logic [24:0] frac;
      frac = '0;
      if (k >= (64'd1 << tb)) begin
         return 25'h1000000;
      end
      m = (64'd1 << 30) + (k << (30 - tb));
      for (int i = 1; i <= 24; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac[24-i] = 1'b1;
         end
      end
      return frac;
   endfunction

   function automatic logic [63:0] isqrt64(logic [63:0] xin);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] bv;
      x  = xin;
      r  = '0;
      bv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bv > x) begin
            bv = bv >> 2;
         end
      end
      for (int i = 0; i < 32; i++) begin
         if (bv != 0) begin
            if (x >= r + bv) begin
               x = x - (r + bv);
               r = (r >> 1) + bv;
            end else begin
               r = r >> 1;
            end
            bv = bv >> 2;
         end
      end
      return r;
   endfunction

   // 2^(f/2^24) in Q1.30, f in [0, 2^24]
   function automatic logic [31:0] ex_point(logic [63:0] f);
      logic [63:0] x;
      logic [63:0] root;
      x    = 64'd1 << 30;
      root = 64'd1 << 31;
      if (f >= (64'd1 << 24)) begin
         return 32'h80000000;
      end
      for (int i = 1; i <= 24; i++) begin
         root = isqrt64(root << 30);
         if (f[24-i]) begin
            x = (x * root + (64'd1 << 29)) >> 30;
         end
      end
      return x[31:0];
   endfunction

   // log2 of a nonzero constant in Q24, same interpolation as the datapath
   function automatic longint log2_c(logic [63:0] v, int tb);
      int          p;
      int          rs;
      logic [63:0] m;
      logic [63:0] mf;
      logic [63:0] k;
      logic [63:0] rem;
      longint      y0;
      longint      y1;
      rs = 30 - tb;
      p  = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            p = i;
         end
      end
      m   = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
      mf  = m - (64'd1 << 30);
      k   = mf >> rs;
      rem = mf & ((64'd1 << rs) - 64'd1);
      y0  = longint'(lg_point(k, tb));
      y1  = longint'(lg_point(k + 64'd1, tb));
      return longint'(p) * (64'sd1 << 24) + y0 +
             longint'(((64'(y1 - y0)) * rem + (64'd1 << (rs - 1))) >> rs);
   endfunction

endpackage

// File: src/brg_log_front.sv
// ----------------------------------------------------------------------------
// brg_log_front
// Log-domain front end: normalizes pad gain and sample, interpolates their
// base-2 logs, forms the log ratio and the Q24 denominator. Seven stages.
// ----------------------------------------------------------------------------
module brg_log_front
   import brg_pkg::*;
#(
   parameter int TABLE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic [31:0]             sample,
   input  logic [31:0]             pad_gain,
   input  logic signed [4:0]       gain_step_b,
   input  logic signed [4:0]       gain_step_g,
   input  logic signed [MUD_W-1:0] mud_term,
   output logic                    out_valid,
   output logic signed [DEN_W-1:0] out_den,
   output brg_flags_type           out_flags
);

   localparam int     TAB_N = 1 << TABLE_BITS;
   localparam int     RS    = 30 - TABLE_BITS;
   localparam int     PW    = 25 + RS;
   localparam logic [PW-1:0] RND = PW'(1) << (RS - 1);
   localparam longint K_L2  = log2_c(K_CD_Q16, TABLE_BITS) - log2_c(K_F_Q16, TABLE_BITS);

   logic [24:0] lg_tab [0:TAB_N];

   for (genvar k = 0; k <= TAB_N; k++) begin : g_lg
      localparam logic [24:0] V = lg_point(64'(k), TABLE_BITS);
      assign lg_tab[k] = V;
   end

   // stage 1: leading one and normalize
   logic [4:0]    p_pad, p_smp;
   logic [31:0]   nv_pad, nv_smp;
   logic          v1_ff;
   logic [4:0]    p_pad1_ff, p_smp1_ff;
   logic [29:0]   mf_pad1_ff, mf_smp1_ff;
   logic signed [6:0] bg1_ff;
   brg_flags_type fl1_ff, fl1_in;

   always_comb begin
      p_pad = '0;
      p_smp = '0;
      for (int i = 0; i < 32; i++) begin
         if (pad_gain[i]) begin
            p_pad = 5'(i);
         end
         if (sample[i]) begin
            p_smp = 5'(i);
         end
      end
      nv_pad = pad_gain << (5'd31 - p_pad);
      nv_smp = sample << (5'd31 - p_smp);
      fl1_in.zero    = (sample == '0);
      fl1_in.invalid = (sample != '0) && (pad_gain == '0);
      fl1_in.sat     = 1'b0;
   end

   // stage 2: table reads
   logic [TABLE_BITS-1:0] k_pad, k_smp;
   logic [TABLE_BITS:0]   k1_pad, k1_smp;
   logic          v2_ff;
   logic [4:0]    p_pad2_ff, p_smp2_ff;
   logic [24:0]   y0_pad2_ff, y0_smp2_ff, dy_pad2_ff, dy_smp2_ff;
   logic [RS-1:0] rem_pad2_ff, rem_smp2_ff;
   logic signed [6:0] bg2_ff;
   brg_flags_type fl2_ff;

   assign k_pad  = mf_pad1_ff[29:RS];
   assign k_smp  = mf_smp1_ff[29:RS];
   assign k1_pad = {1'b0, k_pad} + 1'b1;
   assign k1_smp = {1'b0, k_smp} + 1'b1;

   // stage 3: interpolation products
   logic          v3_ff;
   logic [4:0]    p_pad3_ff, p_smp3_ff;
   logic [24:0]   y0_pad3_ff, y0_smp3_ff;
   logic [PW-1:0] pr_pad3_ff, pr_smp3_ff;
   logic signed [6:0] bg3_ff;
   brg_flags_type fl3_ff;

   // stage 4: per-operand log2 and constant term
   logic          v4_ff;
   logic [29:0]   lg_pad4_ff, lg_smp4_ff;
   logic signed [DEN_W-1:0] kt4_ff;
   brg_flags_type fl4_ff;

   // stage 5: log2 of the ratio
   logic          v5_ff;
   logic signed [DEN_W-1:0] l2_5_ff;
   brg_flags_type fl5_ff;

   // stage 6: scale to base ten
   logic          v6_ff;
   logic signed [57:0] pr6_ff;
   brg_flags_type fl6_ff;

   // stage 7: denominator
   logic          v7_ff;
   logic signed [DEN_W-1:0] den7_ff;
   brg_flags_type fl7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_pad1_ff  <= p_pad;
         p_smp1_ff  <= p_smp;
         mf_pad1_ff <= nv_pad[30:1];
         mf_smp1_ff <= nv_smp[30:1];
         bg1_ff     <= 7'(gain_step_b) - 7'(gain_step_g) + 7'sd3;
         fl1_ff     <= fl1_in;

         p_pad2_ff   <= p_pad1_ff;
         p_smp2_ff   <= p_smp1_ff;
         y0_pad2_ff  <= lg_tab[k_pad];
         y0_smp2_ff  <= lg_tab[k_smp];
         dy_pad2_ff  <= lg_tab[k1_pad] - lg_tab[k_pad];
         dy_smp2_ff  <= lg_tab[k1_smp] - lg_tab[k_smp];
         rem_pad2_ff <= mf_pad1_ff[RS-1:0];
         rem_smp2_ff <= mf_smp1_ff[RS-1:0];
         bg2_ff      <= bg1_ff;
         fl2_ff      <= fl1_ff;

         p_pad3_ff  <= p_pad2_ff;
         p_smp3_ff  <= p_smp2_ff;
         y0_pad3_ff <= y0_pad2_ff;
         y0_smp3_ff <= y0_smp2_ff;
         pr_pad3_ff <= PW'(dy_pad2_ff) * PW'(rem_pad2_ff);
         pr_smp3_ff <= PW'(dy_smp2_ff) * PW'(rem_smp2_ff);
         bg3_ff     <= bg2_ff;
         fl3_ff     <= fl2_ff;

         lg_pad4_ff <= {1'b0, p_pad3_ff, 24'd0} + 30'(y0_pad3_ff) +
                       30'((pr_pad3_ff + RND) >> RS);
         lg_smp4_ff <= {1'b0, p_smp3_ff, 24'd0} + 30'(y0_smp3_ff) +
                       30'((pr_smp3_ff + RND) >> RS);
         kt4_ff     <= DEN_W'(K_L2) + (DEN_W'(bg3_ff) <<< 24);
         fl4_ff     <= fl3_ff;

         l2_5_ff <= $signed({4'd0, lg_pad4_ff}) - $signed({4'd0, lg_smp4_ff}) + kt4_ff;
         fl5_ff  <= fl4_ff;

         pr6_ff <= 58'(l2_5_ff) * 58'(K_LOG10_2) + 58'sd8388608;
         fl6_ff <= fl5_ff;

         den7_ff <= DEN_W'(pr6_ff >>> 24) - DEN_W'(mud_term) - DEN_W'(K_B);
         fl7_ff  <= fl6_ff;
      end
   end

   assign out_valid = v7_ff;
   assign out_den   = den7_ff;
   assign out_flags = fl7_ff;

endmodule

// File: src/brg_divider.sv
// ----------------------------------------------------------------------------
// brg_divider
// Pipelined restoring divider for t = (A << 24) / den, one quotient bit per
// stage after a magnitude stage. The top quotient bit marks overflow.
// ----------------------------------------------------------------------------
module brg_divider
   import brg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic signed [DEN_W-1:0] in_den,
   input  brg_flags_type           in_flags,
   output logic                    out_valid,
   output logic [QUO_W-1:0]        out_quo,
   output logic                    out_neg,
   output brg_flags_type           out_flags
);

   logic             v_ff   [0:QUO_W];
   logic [DIV_W-1:0] d_ff   [0:QUO_W];
   logic [REM_W-1:0] rem_ff [0:QUO_W];
   logic [QUO_W-1:0] q_ff   [0:QUO_W];
   logic             neg_ff [0:QUO_W];
   brg_flags_type    fl_ff  [0:QUO_W];
   brg_flags_type    fl0_in;

   always_comb begin
      fl0_in = in_flags;
      fl0_in.invalid = in_flags.invalid | (!in_flags.zero && in_den == '0);
   end

   // magnitude stage
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff[0]   <= (in_den < 0) ? DIV_W'(-in_den) : DIV_W'(in_den);
         neg_ff[0] <= (in_den < 0);
         rem_ff[0] <= DIV_NUM[REM_W-1:0];
         q_ff[0]   <= '0;
         fl_ff[0]  <= fl0_in;
      end
   end

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BI = QUO_W - 1 - s;
      logic [63:0]      dsh;
      logic [63:0]      diff;
      logic             ge;
      logic [QUO_W-1:0] q_in;

      always_comb begin
         dsh  = {{(64-DIV_W){1'b0}}, d_ff[s]} << BI;
         diff = {{(64-REM_W){1'b0}}, rem_ff[s]} - dsh;
         ge   = ({{(64-REM_W){1'b0}}, rem_ff[s]} >= dsh);
         q_in = q_ff[s];
         q_in[BI] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (adv) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[s+1]   <= d_ff[s];
            rem_ff[s+1] <= ge ? diff[REM_W-1:0] : rem_ff[s];
            q_ff[s+1]   <= q_in;
            neg_ff[s+1] <= neg_ff[s];
            fl_ff[s+1]  <= fl_ff[s];
         end
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign out_quo   = q_ff[QUO_W];
   assign out_neg   = neg_ff[QUO_W];
   assign out_flags = fl_ff[QUO_W];

endmodule

// File: src/brg_exp_back.sv
// ----------------------------------------------------------------------------
// brg_exp_back
// Back end: signs and clamps t, converts to base two, interpolates 2^frac,
// scales to Q16.16 with rounding and drives the result register. Six stages.
// ----------------------------------------------------------------------------
module brg_exp_back
   import brg_pkg::*;
#(
   parameter int TABLE_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [QUO_W-1:0] in_quo,
   input  logic             in_neg,
   input  brg_flags_type    in_flags,
   output logic             out_valid,
   output logic [31:0]      out_corrected,
   output logic             out_saturated,
   output logic             out_invalid
);

   localparam int TAB_N = 1 << TABLE_BITS;
   localparam int RS    = 24 - TABLE_BITS;
   localparam int PW    = 32 + RS;
   localparam logic [PW-1:0] RND = PW'(1) << (RS - 1);

   logic [31:0] ex_tab [0:TAB_N];

   for (genvar k = 0; k <= TAB_N; k++) begin : g_ex
      localparam logic [31:0] V = ex_point(64'(k) << RS);
      assign ex_tab[k] = V;
   end

   // stage 1: signed t and range flags
   logic               v1_ff;
   logic signed [28:0] t1_ff;
   brg_flags_type      fl1_ff, fl1_in;

   always_comb begin
      fl1_in = in_flags;
      fl1_in.sat  = !in_flags.zero && !in_flags.invalid && !in_neg && (in_quo > T_SAT_LIM);
      fl1_in.zero = in_flags.zero | (!in_flags.invalid && in_neg && (in_quo > T_TINY_LIM));
   end

   // stage 2: t * log2(10)
   logic               v2_ff;
   logic signed [55:0] pr2_ff;
   brg_flags_type      fl2_ff;

   // stage 3: split exponent, table reads
   logic signed [31:0]    e3;
   logic signed [7:0]     n3;
   logic [TABLE_BITS-1:0] k3;
   logic [TABLE_BITS:0]   k13;
   logic                  v3_ff;
   logic [31:0]           y0_3_ff, dy3_ff;
   logic [RS-1:0]         rem3_ff;
   logic signed [7:0]     sh3_ff;
   brg_flags_type         fl3_ff;

   assign e3  = 32'(pr2_ff >>> 24);
   assign n3  = 8'(e3 >>> 24);
   assign k3  = e3[23:RS];
   assign k13 = {1'b0, k3} + 1'b1;

   // stage 4: interpolation product
   logic              v4_ff;
   logic [31:0]       y0_4_ff;
   logic [PW-1:0]     pr4_ff;
   logic signed [7:0] sh4_ff;
   brg_flags_type     fl4_ff;

   // stage 5: mantissa in Q1.30
   logic              v5_ff;
   logic [32:0]       x5_ff;
   logic signed [7:0] sh5_ff;
   brg_flags_type     fl5_ff;

   // stage 6: scale, round, select
   logic [63:0] xs;
   logic [63:0] vsc;
   logic [5:0]  rs_amt;
   logic [31:0] corr_in;
   logic        sat_in;

   always_comb begin
      xs     = {31'd0, x5_ff};
      rs_amt = 6'(-sh5_ff);
      if (sh5_ff >= 0) begin
         vsc = xs << sh5_ff[1:0];
      end else begin
         vsc = (xs + (64'd1 << (rs_amt - 6'd1))) >> rs_amt;
      end
      corr_in = '0;
      sat_in  = 1'b0;
      if (fl5_ff.invalid || fl5_ff.zero) begin
         corr_in = '0;
      end else if (fl5_ff.sat || (vsc > 64'hFFFFFFFF)) begin
         corr_in = 32'hFFFFFFFF;
         sat_in  = 1'b1;
      end else begin
         corr_in = vsc[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
         out_valid <= 1'b0;
      end else if (adv) begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         v4_ff     <= v3_ff;
         v5_ff     <= v4_ff;
         out_valid <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff  <= in_neg ? -$signed({1'b0, in_quo}) : $signed({1'b0, in_quo});
         fl1_ff <= fl1_in;

         pr2_ff <= 56'(t1_ff) * 56'(K_LOG2_10) + 56'sd8388608;
         fl2_ff <= fl1_ff;

         y0_3_ff <= ex_tab[k3];
         dy3_ff  <= ex_tab[k13] - ex_tab[k3];
         rem3_ff <= e3[RS-1:0];
         sh3_ff  <= n3 - 8'sd14;
         fl3_ff  <= fl2_ff;

         y0_4_ff <= y0_3_ff;
         pr4_ff  <= PW'(dy3_ff) * PW'(rem3_ff);
         sh4_ff  <= sh3_ff;
         fl4_ff  <= fl3_ff;

         x5_ff  <= 33'(y0_4_ff) + 33'((pr4_ff + RND) >> RS);
         sh5_ff <= sh4_ff;
         fl5_ff <= fl4_ff;

         out_corrected <= corr_in;
         out_saturated <= sat_in;
         out_invalid   <= fl5_ff.invalid;
      end
   end

endmodule

// File: src/button_gain_recovery_unit.sv
// ----------------------------------------------------------------------------
// button_gain_recovery_unit
// Recovers a corrected button value 10^t from a raw sample, pad gain and
// gain step codes, in unsigned Q16.16 with saturate and invalid flags.
// ----------------------------------------------------------------------------
// Accepts one item per clock while req_stall is low and returns exactly one
// result item per input item, in order. The pipeline is 42 register stages
// deep: 7 log-domain stages (leading one, table read, interpolation
// multiply, per-operand log, log ratio, base-ten scale, denominator), 29
// divider stages (a magnitude stage, then one quotient bit per stage for
// the 28-bit quotient), and 6 back-end stages ending in the result
// register. The whole pipeline advances together: while a result sits in
// the output register with rsp_stall high, everything holds and req_stall
// is raised, so nothing is dropped or repeated. Bubbles are carried as
// invalid slots. The log_mud_resistivity register is written through
// csr_wen/csr_wdata; its scaled term is registered in the cycle after the
// write and is picked up at the denominator stage, so write it only while
// no item is in flight. A zero sample gives a zero result with no flag; a
// zero pad gain or zero denominator gives invalid with a zero value; large
// results clip to 0xFFFFFFFF with saturated set.
// ----------------------------------------------------------------------------
module button_gain_recovery_unit
   import brg_pkg::*;
#(
   parameter int TABLE_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [31:0]             req_sample,
   input  logic [31:0]             req_pad_gain,
   input  logic signed [4:0]       req_gain_step_b,
   input  logic signed [4:0]       req_gain_step_g,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [31:0]             rsp_corrected,
   output logic                    rsp_saturated,
   output logic                    rsp_invalid,
   input  logic                    csr_wen,
   input  logic signed [MUD_W-1:0] csr_wdata
);

   logic adv;

   // global advance: hold only when a finished item is refused downstream
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // mud resistivity register and its Q24 term log10(Rm)*(A-1)
   logic signed [MUD_W-1:0] mud_ff;
   logic signed [51:0]      mud_pr;
   logic signed [MUD_W-1:0] mud_term_ff;

   assign mud_pr = 52'(mud_ff) * 52'(K_A_M1) + 52'sd8388608;

   always_ff @(posedge clock) begin
      if (reset) begin
         mud_ff      <= '0;
         mud_term_ff <= '0;
      end else begin
         if (csr_wen) begin
            mud_ff <= csr_wdata;
         end
         mud_term_ff <= MUD_W'(mud_pr >>> 24);
      end
   end

   logic                    fe_valid;
   logic signed [DEN_W-1:0] fe_den;
   brg_flags_type           fe_flags;

   brg_log_front #(
      .TABLE_BITS (TABLE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .sample      (req_sample),
      .pad_gain    (req_pad_gain),
      .gain_step_b (req_gain_step_b),
      .gain_step_g (req_gain_step_g),
      .mud_term    (mud_term_ff),
      .out_valid   (fe_valid),
      .out_den     (fe_den),
      .out_flags   (fe_flags)
   );

   logic             dv_valid;
   logic [QUO_W-1:0] dv_quo;
   logic             dv_neg;
   brg_flags_type    dv_flags;

   brg_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fe_valid),
      .in_den    (fe_den),
      .in_flags  (fe_flags),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_neg   (dv_neg),
      .out_flags (dv_flags)
   );

   brg_exp_back #(
      .TABLE_BITS (TABLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (dv_valid),
      .in_quo        (dv_quo),
      .in_neg        (dv_neg),
      .in_flags      (dv_flags),
      .out_valid     (rsp_valid),
      .out_corrected (rsp_corrected),
      .out_saturated (rsp_saturated),
      .out_invalid   (rsp_invalid)
   );

endmodule

// File: bench/button_gain_recovery_unit_tb.sv
// ----------------------------------------------------------------------------
// button_gain_recovery_unit_tb
// Self-checking bench for the button gain recovery pipeline. A scoreboard
// class predicts each corrected value from its own log/exp tables, and the
// monitor compares every result item in order, under random idling and stall.
// ----------------------------------------------------------------------------
module button_gain_recovery_unit_tb;

   // fixed-point constants of the recovery formula
   localparam longint ONE_Q24   = 64'sd1 << 24;
   localparam longint CD_Q16    = 64'sd5052879864;
   localparam longint F_Q16     = 64'sd116654;
   localparam longint L10_OF_2  = 64'sd5050445;
   localparam longint L2_OF_10  = 64'sd55732705;
   localparam longint EXP_A     = 64'sd18975031;
   localparam longint EXP_A_M1  = 64'sd2197815;
   localparam longint OFS_B     = 64'sd68904026;
   localparam int     SEG_BITS  = 8;
   localparam int     LOG_RS    = 30 - SEG_BITS;
   localparam int     EXP_RS    = 24 - SEG_BITS;
   localparam longint MUD_MAX   = 134217727;
   localparam longint MUD_MIN   = -134217728;
   localparam int     CYCLE_CAP = 1000000;

   typedef struct {
      logic [31:0]       sample;
      logic [31:0]       pad;
      logic signed [4:0] step_b;
      logic signed [4:0] step_g;
   } button_item_t;

   typedef struct {
      logic [31:0] corrected;
      logic        saturated;
      logic        invalid;
   } recovery_t;

   // predicts and checks recovered values
   class recovery_board;
      longint     mud;            // log10 Rm, Q24
      longint     log_seg[257];   // log2(1+k/256), Q24
      logic [63:0] exp_seg[257];  // 2^(k/256), Q1.30
      longint     log_cd_minus_f;
      recovery_t  pending_q[$];
      int         errors;
      int         checked;
      int         n_sat, n_inv, n_zero;

      function new();
         logic [63:0] m, x;
         logic [63:0] roots[25];
         longint      fr;
         mud = 0;
         errors = 0;
         checked = 0;
         n_sat = 0; n_inv = 0; n_zero = 0;
         for (int k = 0; k < 256; k++) begin
            m = (64'd1 << 30) + (64'(k) << LOG_RS);
            fr = 0;
            for (int i = 1; i <= 24; i++) begin
               m = (m * m) >> 30;
               if (m >= (64'd1 << 31)) begin
                  m = m >> 1;
                  fr = fr | (64'sd1 << (24 - i));
               end
            end
            log_seg[k] = fr;
         end
         log_seg[256] = ONE_Q24;
         roots[0] = 64'd1 << 31;
         for (int i = 1; i <= 24; i++) roots[i] = int_sqrt(roots[i-1] << 30);
         for (int k = 0; k < 256; k++) begin
            x = 64'd1 << 30;
            for (int i = 1; i <= 24; i++) begin
               if (((64'(k) << EXP_RS) >> (24 - i)) & 64'd1)
                  x = (x * roots[i] + (64'd1 << 29)) >> 30;
            end
            exp_seg[k] = x;
         end
         exp_seg[256] = 64'd1 << 31;
         log_cd_minus_f = log2_q(CD_Q16) - log2_q(F_Q16);
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] xin);
         logic [63:0] x, r, bv;
         x = xin;
         r = 0;
         bv = 64'd1 << 62;
         while (bv > x) bv = bv >> 2;
         while (bv != 0) begin
            if (x >= r + bv) begin
               x = x - (r + bv);
               r = (r >> 1) + bv;
            end else begin
               r = r >> 1;
            end
            bv = bv >> 2;
         end
         return r;
      endfunction

      function longint log2_q(logic [63:0] v);
         int          p;
         logic [63:0] m, mf, k, rem, d;
         p = 0;
         for (int i = 0; i < 64; i++) if (v[i]) p = i;
         m   = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
         mf  = m - (64'd1 << 30);
         k   = mf >> LOG_RS;
         rem = mf & ((64'd1 << LOG_RS) - 1);
         d   = 64'(log_seg[k+1] - log_seg[k]);
         return longint'(p) * ONE_Q24 + log_seg[k] +
                longint'((d * rem + (64'd1 << (LOG_RS - 1))) >> LOG_RS);
      endfunction

      function logic [63:0] exp2_q(logic [63:0] f);
         logic [63:0] k, rem;
         k   = f >> EXP_RS;
         rem = f & ((64'd1 << EXP_RS) - 1);
         return exp_seg[k] + (((exp_seg[k+1] - exp_seg[k]) * rem +
                (64'd1 << (EXP_RS - 1))) >> EXP_RS);
      endfunction

      function longint mul_q(longint a, longint b);
         return (a * b + (64'sd1 << 23)) >>> 24;
      endfunction

      // Q24 denominator of the exponent, pad and sample nonzero
      function longint denom(longint md, button_item_t it);
         longint l2;
         l2 = log2_q(64'(it.pad)) - log2_q(64'(it.sample)) + log_cd_minus_f +
              longint'(int'(it.step_b) - int'(it.step_g) + 3) * ONE_Q24;
         return mul_q(l2, L10_OF_2) - mul_q(md, EXP_A_M1) - OFS_B;
      endfunction

      function recovery_t recover(button_item_t it);
         recovery_t   r;
         longint      den, t, e, n, sh;
         logic [63:0] x, v;
         r = '{32'd0, 1'b0, 1'b0};
         if (it.sample == 0) return r;
         if (it.pad == 0) begin
            r.invalid = 1'b1;
            return r;
         end
         den = denom(mud, it);
         if (den == 0) begin
            r.invalid = 1'b1;
            return r;
         end
         t = (EXP_A * ONE_Q24) / den;
         if (t > 5 * ONE_Q24) begin
            r.corrected = 32'hFFFFFFFF;
            r.saturated = 1'b1;
            return r;
         end
         if (t < -6 * ONE_Q24) return r;
         e  = mul_q(t, L2_OF_10);
         n  = e >>> 24;
         x  = exp2_q(64'(e - n * ONE_Q24));
         sh = n - 14;
         if (sh >= 0) v = x << sh;
         else v = (x + (64'd1 << (-sh - 1))) >> (-sh);
         if (v > 64'hFFFFFFFF) begin
            r.corrected = 32'hFFFFFFFF;
            r.saturated = 1'b1;
         end else begin
            r.corrected = v[31:0];
         end
         return r;
      endfunction

      function void note_item(button_item_t it);
         recovery_t r;
         r = recover(it);
         if (r.saturated) n_sat++;
         if (r.invalid) n_inv++;
         if (r.corrected == 0 && !r.invalid) n_zero++;
         pending_q.push_back(r);
      endfunction

      function void check_result(recovery_t got);
         recovery_t want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: result item with nothing expected");
            return;
         end
         want = pending_q.pop_front();
         checked++;
         if (got.corrected !== want.corrected || got.saturated !== want.saturated ||
             got.invalid !== want.invalid) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: item %0d exp %h sat %b inv %b, got %h sat %b inv %b",
                        checked, want.corrected, want.saturated, want.invalid,
                        got.corrected, got.saturated, got.invalid);
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [31:0]             req_sample;
   logic [31:0]             req_pad_gain;
   logic signed [4:0]       req_gain_step_b;
   logic signed [4:0]       req_gain_step_g;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [31:0]             rsp_corrected;
   logic                    rsp_saturated;
   logic                    rsp_invalid;
   logic                    csr_wen;
   logic signed [27:0]      csr_wdata;

   recovery_board board;
   int  cycles = 0;
   int  stall_left = 0;
   int  sent = 0;

   button_gain_recovery_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_pad_gain    (req_pad_gain),
      .req_gain_step_b (req_gain_step_b),
      .req_gain_step_g (req_gain_step_g),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_corrected   (rsp_corrected),
      .rsp_saturated   (rsp_saturated),
      .rsp_invalid     (rsp_invalid),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one window in every four of the cycle count runs with no idling at all
   function automatic bit calm_window();
      return ((cycles >> 9) % 4) == 1;
   endfunction

   // cycle cap: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stall, check each accepted item
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            board.check_result('{rsp_corrected, rsp_saturated, rsp_invalid});
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else if (calm_window() || $urandom_range(0, 99) < 70) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left <= gap_len();
            rsp_stall  <= 1'b1;
         end
      end
   end

   // present one item, hold until accepted, then maybe idle
   task automatic send_item(button_item_t it);
      int gap;
      req_valid       <= 1'b1;
      req_sample      <= it.sample;
      req_pad_gain    <= it.pad;
      req_gain_step_b <= it.step_b;
      req_gain_step_g <= it.step_g;
      do @(posedge clock); while (req_stall);
      board.note_item(it);
      sent++;
      gap = calm_window() ? 0 : gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(logic [31:0] s, logic [31:0] p,
                              logic signed [4:0] b, logic signed [4:0] g);
      button_item_t it;
      it = '{s, p, b, g};
      send_item(it);
   endtask

   // drain the pipeline, then write log10 Rm while idle
   task automatic set_mud(longint v);
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v[27:0];
      @(posedge clock);
      csr_wen   <= 1'b0;
      repeat (4) @(posedge clock);
      board.mud = v;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 19))
         0:        return 32'd0;
         1:        return 32'hFFFFFFFF;
         2, 3, 4:  return $urandom_range(1, 255);
         5, 6, 7:  return $urandom_range(32768, 131072);   // near unity
         8, 9, 10: return $urandom_range(1, 1 << 24);
         default:  return $urandom;
      endcase
   endfunction

   task automatic random_phase(int count);
      button_item_t it;
      for (int i = 0; i < count; i++) begin
         it.sample = rand_word();
         it.pad    = rand_word();
         it.step_b = 5'($urandom);
         it.step_g = 5'($urandom);
         send_item(it);
      end
   endtask

   initial begin
      button_item_t zit;
      longint       l10, guess, zmud;
      bit           found;
      board           = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_sample      <= '0;
      req_pad_gain    <= '0;
      req_gain_step_b <= '0;
      req_gain_step_g <= '0;
      csr_wen         <= 1'b0;
      csr_wdata       <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: zero sample, zero pad, field extremes, saturate and tiny
      send_fields(32'd0, 32'd0, 5'sd0, 5'sd0);
      send_fields(32'd0, 32'hFFFFFFFF, 5'sd15, -5'sd16);
      send_fields(32'h00010000, 32'd0, 5'sd0, 5'sd0);
      send_fields(32'hFFFFFFFF, 32'hFFFFFFFF, 5'sd0, 5'sd0);
      send_fields(32'd1, 32'hFFFFFFFF, 5'sd15, -5'sd16);
      send_fields(32'hFFFFFFFF, 32'd1, -5'sd16, 5'sd15);
      send_fields(32'd1, 32'd1, 5'sd15, 5'sd15);
      send_fields(32'd1, 32'd1, -5'sd16, -5'sd16);
      send_fields(32'h00010000, 32'h00010000, 5'sd0, 5'sd0);
      send_fields(32'h00010000, 32'h00010000, -5'sd2, 5'sd3);
      send_fields(32'h00010000, 32'h00010000, -5'sd5, 5'sd0);
      send_fields(32'h00010000, 32'h00010000, 5'sd0, 5'sd7);
      send_fields(32'h55555555, 32'hAAAAAAAA, 5'sd10, -5'sd11);
      send_fields(32'hAAAAAAAA, 32'h55555555, -5'sd11, 5'sd10);
      send_fields(32'h00000100, 32'h01000000, 5'sd4, 5'sd1);
      send_fields(32'h7FFFFFFF, 32'h80000000, 5'sd1, 5'sd4);
      for (int j = -16; j < 16; j += 4) send_fields(32'h00012000, 32'h0000E000, 5'(j), 5'sd0);

      set_mud(MUD_MAX);
      random_phase(300);
      set_mud(MUD_MIN);
      random_phase(300);

      // find a log10 Rm that makes the denominator exactly zero
      found = 1'b0;
      zmud  = 0;
      zit   = '{32'h00010000, 32'h00010000, 5'sd0, 5'sd0};
      for (int bb = -16; bb < 16 && !found; bb++) begin
         zit.step_b = 5'(bb);
         l10   = board.denom(0, zit);
         guess = (l10 * ONE_Q24) / EXP_A_M1;
         for (longint d = -4; d <= 4 && !found; d++) begin
            if (guess + d >= MUD_MIN && guess + d <= MUD_MAX &&
                board.denom(guess + d, zit) == 0) begin
               found = 1'b1;
               zmud  = guess + d;
            end
         end
      end
      set_mud(zmud);
      if (found) begin
         send_item(zit);
         // neighbors on both sides of the pole: huge t either way
         send_fields(32'h00010001, 32'h00010000, zit.step_b, 5'sd0);
         send_fields(32'h00010000, 32'h00010001, zit.step_b, 5'sd0);
      end
      random_phase(150);

      for (int ph = 0; ph < 4; ph++) begin
         set_mud($signed(28'($urandom)));
         random_phase(250);
      end
      set_mud(0);
      random_phase(100);

      // drain, then let the pipeline run out
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.pending_q.size() != 0) board.errors++;

      $display("%0d items sent, %0d results checked, %0d errors", sent, board.checked,
               board.errors);
      $display("saturated %0d, invalid %0d, zero %0d, pole setting found %0b",
               board.n_sat, board.n_inv, board.n_zero, found);
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: files.f
src/brg_pkg.sv
src/brg_log_front.sv
src/brg_divider.sv
src/brg_exp_back.sv
src/button_gain_recovery_unit.sv
bench/button_gain_recovery_unit_tb.sv
